[rtl/core/krpr_pkg.sv]
// ============================================================================
// krpr_pkg
// Shared types and constants for the key report press/release event block.
// ============================================================================
package krpr_pkg;

    // defaults for the top-level parameters
    localparam int C_HELD_SLOTS_DEF  = 8;
    localparam int C_REPORT_KEYS_DEF = 8;

    // fixed field widths and constants
    localparam int C_KEY_W       = 16;
    localparam int C_MOD_BITS    = 8;
    localparam int C_MAX_KEYS    = 8;
    localparam logic [C_KEY_W-1:0] C_MOD_CODE_BASE = 16'd300;
    localparam logic [C_KEY_W-1:0] C_MASK_RESET    = 16'h4000;
    localparam logic [C_KEY_W-1:0] C_EMPTY_CODE    = 16'h0000;

    // one keyboard report
    typedef struct packed {
        logic [7:0]         modifier_bits;
        logic [3:0]         key_count;
        logic [C_KEY_W-1:0] key_0;
        logic [C_KEY_W-1:0] key_1;
        logic [C_KEY_W-1:0] key_2;
        logic [C_KEY_W-1:0] key_3;
        logic [C_KEY_W-1:0] key_4;
        logic [C_KEY_W-1:0] key_5;
        logic [C_KEY_W-1:0] key_6;
        logic [C_KEY_W-1:0] key_7;
    } t_report;

    // one press or release event
    typedef struct packed {
        logic               is_release;
        logic [C_KEY_W-1:0] event_code;
        logic               last_event;
    } t_event;

    // sequencer to event stage
    typedef struct packed {
        logic               push;
        logic               flush;
        logic               is_release;
        logic [C_KEY_W-1:0] event_code;
    } t_evt_req;

    // event stage to sequencer
    typedef struct packed {
        logic free;
        logic pend_valid;
    } t_evt_stat;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MODS  = 6'b000010,
        S_RD    = 6'b000100,
        S_CHK   = 6'b001000,
        S_PRESS = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

[rtl/core/krpr_held_ram.sv]
// ============================================================================
// krpr_held_ram
// Held key code memory: one write port, one read port, registered read data.
// ============================================================================
module krpr_held_ram
    import krpr_pkg::*;
#(
    parameter int DEPTH  = C_HELD_SLOTS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  logic [C_KEY_W-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output logic [C_KEY_W-1:0] o_rd_data
);

    logic [C_KEY_W-1:0] r_mem [DEPTH];
    logic [C_KEY_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/krpr_evt_out.sv]
// ============================================================================
// krpr_evt_out
// Event output stage: holds one pending event so the final event of a report
// can be flagged, and drives the output register toward the consumer.
// ============================================================================
module krpr_evt_out
    import krpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_evt_req  i_req,
    output t_evt_stat o_stat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_event    o_out
);

    logic               r_out_valid;
    t_event             r_out;
    logic               r_pend_valid;
    logic               r_pend_rel;
    logic [C_KEY_W-1:0] r_pend_code;
    logic               w_free;
    logic               w_load;
    logic               w_flush;

    // output register can take a new transaction this cycle
    assign w_free  = !r_out_valid || i_out_ready;
    assign w_load  = i_req.push && r_pend_valid;
    assign w_flush = !i_req.push && i_req.flush && w_free && r_pend_valid;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (w_load || w_flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_req.push) begin
                r_pend_valid <= 1'b1;
            end else if (w_flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load || w_flush) begin
            r_out.is_release <= r_pend_rel;
            r_out.event_code <= r_pend_code;
            r_out.last_event <= w_flush;
        end
        if (i_req.push) begin
            r_pend_rel  <= i_req.is_release;
            r_pend_code <= i_req.event_code;
        end
    end

    assign o_stat.free       = w_free;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    // a final event on the output means nothing of the report is still pending
    a_last_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_event) |-> !r_pend_valid)
        else $error("last event shown while an event is still pending");

endmodule

[rtl/core/key_report_to_press_release_events.sv]
// ============================================================================
// key_report_to_press_release_events
// Turns keyboard reports into key press and release events, keeping the
// previous modifier byte and a memory of held key codes.
// Events: each event waits in a pending register until the next one arrives, so
//   the final one can be flagged; a lone event shows only after the last state.
// Order: a report with keys walks the modifier bits, then every held slot, with
//   a check for each valid slot, then the report keys; an empty report is taken
//   with no events. A new report is taken only after the last one is done, and a
//   stalled consumer holds the sequencer.
// Reset: mask to 0x4000, previous modifiers to zero, all slot valid bits
//   cleared so the held-key memory needs no clearing pass.
// ============================================================================
module key_report_to_press_release_events
    import krpr_pkg::*;
#(
    parameter int HELD_SLOTS  = C_HELD_SLOTS_DEF,
    parameter int REPORT_KEYS = C_REPORT_KEYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [C_KEY_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_report            i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_event             o_out
);

    localparam int SLOT_W = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
    localparam int SCNT_W = $clog2(HELD_SLOTS + 1);
    localparam int KEY_IW = (REPORT_KEYS > 1) ? $clog2(REPORT_KEYS) : 1;
    localparam int KIDX_W = $clog2(REPORT_KEYS + 1);
    localparam int BIT_W  = $clog2(C_MOD_BITS);

    t_state              r_state, n_state;
    logic [C_KEY_W-1:0]  r_mask;
    logic [7:0]          r_prev_mods, n_prev_mods;
    logic [7:0]          r_mods;
    logic [C_KEY_W-1:0]  r_codes [REPORT_KEYS];
    logic [KIDX_W-1:0]   r_count;
    logic                r_zero;
    logic [REPORT_KEYS-1:0] r_mark, n_mark;
    logic [HELD_SLOTS-1:0]  r_valid, n_valid;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [SCNT_W-1:0]   r_slot, n_slot;
    logic [KIDX_W-1:0]   r_kidx, n_kidx;

    logic [C_KEY_W-1:0]  w_raw [C_MAX_KEYS];
    logic [KIDX_W-1:0]   w_count;
    logic                w_zero;
    logic                w_accept;
    logic                w_mod_chg;
    logic [C_KEY_W-1:0]  w_rd_data;
    logic [REPORT_KEYS-1:0] w_hit;
    logic                w_found;
    logic [C_KEY_W-1:0]  w_cur_code;
    logic [REPORT_KEYS-1:0] w_same;
    logic                w_has_free;
    logic [SLOT_W-1:0]   w_free_slot;
    logic                w_rd_en;
    logic                w_wr_en;
    t_evt_req            w_req;
    t_evt_stat           w_stat;

    // report key fields as an array
    assign w_raw[0] = i_in.key_0;
    assign w_raw[1] = i_in.key_1;
    assign w_raw[2] = i_in.key_2;
    assign w_raw[3] = i_in.key_3;
    assign w_raw[4] = i_in.key_4;
    assign w_raw[5] = i_in.key_5;
    assign w_raw[6] = i_in.key_6;
    assign w_raw[7] = i_in.key_7;

    // saturate count and look for a zero code among the valid keys
    always_comb begin
        if (i_in.key_count > 4'(REPORT_KEYS)) begin
            w_count = KIDX_W'(REPORT_KEYS);
        end else begin
            w_count = KIDX_W'(i_in.key_count);
        end
        w_zero = 1'b0;
        for (int j = 0; j < REPORT_KEYS; j++) begin
            if ((KIDX_W'(j) < w_count) && ((w_raw[j] & ~r_mask) == C_EMPTY_CODE)) begin
                w_zero = 1'b1;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    // modifier bit under scan
    assign w_mod_chg = r_prev_mods[r_bit] ^ r_mods[r_bit];

    // held entry compared against every report key
    always_comb begin
        for (int j = 0; j < REPORT_KEYS; j++) begin
            w_hit[j] = (KIDX_W'(j) < r_count) && (r_codes[j] == w_rd_data);
        end
    end
    assign w_found = |w_hit;

    // report key under press and its duplicates
    assign w_cur_code = r_codes[r_kidx[KEY_IW-1:0]];
    always_comb begin
        for (int j = 0; j < REPORT_KEYS; j++) begin
            w_same[j] = (r_codes[j] == w_cur_code);
        end
    end

    // first free slot
    always_comb begin
        w_has_free  = 1'b0;
        w_free_slot = '0;
        for (int i = HELD_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_has_free  = 1'b1;
                w_free_slot = SLOT_W'(i);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_prev_mods = r_prev_mods;
        n_mark      = r_mark;
        n_valid     = r_valid;
        n_bit       = r_bit;
        n_slot      = r_slot;
        n_kidx      = r_kidx;
        w_req       = '0;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (w_count != '0)) begin
                    n_state = S_MODS;
                    n_bit   = '0;
                    n_mark  = '0;
                end
            end
            S_MODS: begin
                w_req.is_release = r_prev_mods[r_bit];
                w_req.event_code = C_MOD_CODE_BASE + C_KEY_W'(r_bit);
                if (!w_mod_chg || w_stat.free) begin
                    w_req.push = w_mod_chg;
                    if (r_bit == BIT_W'(C_MOD_BITS - 1)) begin
                        n_state     = S_RD;
                        n_slot      = '0;
                        n_prev_mods = r_mods;
                    end else begin
                        n_bit = r_bit + 1'b1;
                    end
                end
            end
            S_RD: begin
                if (r_slot == SCNT_W'(HELD_SLOTS)) begin
                    n_state = S_PRESS;
                    n_kidx  = '0;
                end else if (!r_valid[r_slot[SLOT_W-1:0]]) begin
                    n_slot = r_slot + 1'b1;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                w_req.is_release = 1'b1;
                w_req.event_code = w_rd_data;
                if (r_zero || !w_found) begin
                    if (w_stat.free) begin
                        w_req.push                  = 1'b1;
                        n_valid[r_slot[SLOT_W-1:0]] = 1'b0;
                        n_slot                      = r_slot + 1'b1;
                        n_state                     = S_RD;
                    end
                end else begin
                    n_mark  = r_mark | w_hit;
                    n_slot  = r_slot + 1'b1;
                    n_state = S_RD;
                end
            end
            S_PRESS: begin
                w_req.is_release = 1'b0;
                w_req.event_code = w_cur_code;
                if (r_kidx == r_count) begin
                    n_state = S_DONE;
                end else if ((w_cur_code == C_EMPTY_CODE) || r_mark[r_kidx[KEY_IW-1:0]]
                             || !w_has_free) begin
                    n_kidx = r_kidx + 1'b1;
                end else if (w_stat.free) begin
                    w_req.push           = 1'b1;
                    w_wr_en              = 1'b1;
                    n_valid[w_free_slot] = 1'b1;
                    n_mark               = r_mark | w_same;
                    n_kidx               = r_kidx + 1'b1;
                end
            end
            S_DONE: begin
                w_req.flush = 1'b1;
                if (!w_stat.pend_valid || w_stat.free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= C_MASK_RESET;
            r_prev_mods <= '0;
            r_valid     <= '0;
            r_mark      <= '0;
            r_bit       <= '0;
            r_slot      <= '0;
            r_kidx      <= '0;
        end else begin
            r_state     <= n_state;
            r_prev_mods <= n_prev_mods;
            r_valid     <= n_valid;
            r_mark      <= n_mark;
            r_bit       <= n_bit;
            r_slot      <= n_slot;
            r_kidx      <= n_kidx;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    // report capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mods  <= i_in.modifier_bits;
            r_count <= w_count;
            r_zero  <= w_zero;
            for (int j = 0; j < REPORT_KEYS; j++) begin
                r_codes[j] <= w_raw[j] & ~r_mask;
            end
        end
    end

    // held-key memory
    krpr_held_ram #(
        .DEPTH  (HELD_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_held_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_free_slot),
        .i_wr_data (w_cur_code),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_slot[SLOT_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // event output stage
    krpr_evt_out u_evt_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // no event of a finished report is left pending while idle
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_stat.pend_valid)
        else $error("event left pending after report finished");

    // a press only fills an empty slot and never stores an empty code
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (!r_valid[w_free_slot] && (w_cur_code != C_EMPTY_CODE)))
        else $error("press written to an occupied slot or with an empty code");

    // a memory read is always followed by its check
    a_read_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |=> (r_state == S_CHK))
        else $error("held-key read not followed by its check");

endmodule

[sim/key_report_to_press_release_events_tb.sv]
// ============================================================================
// key_report_to_press_release_events_tb
// Self-checking bench for the keyboard report to press/release event block.
// A driver feeds reports from a queue and a monitor compares every event
// with an in-bench model of the modifier byte and the held-key table.
// A directed set is followed by random report streams under several keypad
// masks, with random stalls on both sides.
// ============================================================================
module key_report_to_press_release_events_tb
    import krpr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HELD_SLOTS    = C_HELD_SLOTS_DEF;
    localparam int REPORT_KEYS   = C_REPORT_KEYS_DEF;
    localparam int RESET_CYCLES  = 9;
    localparam int DRAIN_CYCLES  = 64;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int POOL_SIZE     = 11;
    localparam logic [C_KEY_W-1:0] KEYPAD_BIT = 16'h4000;

    // clock, reset and block ports
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [C_KEY_W-1:0] cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_report            in_report = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_event             out_event;

    // model state of the block
    logic [C_KEY_W-1:0]    keypad_mask = C_MASK_RESET;
    logic [C_MOD_BITS-1:0] held_mods   = '0;
    logic [C_KEY_W-1:0]    held_codes [HELD_SLOTS] = '{default: '0};

    // stimulus and scoreboard
    t_report pending_reports [$];
    t_event  expected_events [$];
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      error_count   = 0;
    int      cycle_count   = 0;
    bit      drain_pause   = 1'b0;

    // previous random report, used to build rollover sequences
    logic [C_KEY_W-1:0]    stim_keys [C_MAX_KEYS] = '{default: '0};
    logic [3:0]            stim_count = '0;
    logic [C_MOD_BITS-1:0] stim_mods  = '0;
    logic [C_KEY_W-1:0]    code_pool [POOL_SIZE];

    key_report_to_press_release_events #(
        .HELD_SLOTS  (HELD_SLOTS),
        .REPORT_KEYS (REPORT_KEYS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_report),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_event)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic t_event make_event(input logic rel, input logic [C_KEY_W-1:0] code);
        t_event ev;
        ev.is_release = rel;
        ev.event_code = code;
        ev.last_event = 1'b0;
        return ev;
    endfunction

    function automatic logic [C_KEY_W-1:0] report_key(input t_report r, input int j);
        case (j)
            0: return r.key_0;
            1: return r.key_1;
            2: return r.key_2;
            3: return r.key_3;
            4: return r.key_4;
            5: return r.key_5;
            6: return r.key_6;
            default: return r.key_7;
        endcase
    endfunction

    // works out the events of one report and updates the model state
    function automatic void predict_events(input t_report r);
        logic [C_KEY_W-1:0] codes [C_MAX_KEYS];
        t_event evs [$];
        int n_keys, b, j, s;
        bit zero_seen, found, placed;
        n_keys = int'(r.key_count);
        // empty report leaves everything alone, modifiers included
        if (n_keys == 0)
            return;
        if (n_keys > REPORT_KEYS)
            n_keys = REPORT_KEYS;

        // modifier edges, bit 0 first
        for (b = 0; b < C_MOD_BITS; b++) begin
            if (!held_mods[b] && r.modifier_bits[b])
                evs.push_back(make_event(1'b0, C_MOD_CODE_BASE + 16'(b)));
            else if (held_mods[b] && !r.modifier_bits[b])
                evs.push_back(make_event(1'b1, C_MOD_CODE_BASE + 16'(b)));
        end
        held_mods = r.modifier_bits;

        zero_seen = 1'b0;
        for (j = 0; j < n_keys; j++) begin
            codes[j] = report_key(r, j) & ~keypad_mask;
            if (codes[j] == C_EMPTY_CODE)
                zero_seen = 1'b1;
        end

        // a zero code releases the whole table
        if (zero_seen) begin
            for (s = 0; s < HELD_SLOTS; s++) begin
                if (held_codes[s] != C_EMPTY_CODE) begin
                    evs.push_back(make_event(1'b1, held_codes[s]));
                    held_codes[s] = C_EMPTY_CODE;
                end
            end
        end

        // release held keys missing from the report
        for (s = 0; s < HELD_SLOTS; s++) begin
            if (held_codes[s] != C_EMPTY_CODE) begin
                found = 1'b0;
                for (j = 0; j < n_keys; j++)
                    if (codes[j] == held_codes[s])
                        found = 1'b1;
                if (!found) begin
                    evs.push_back(make_event(1'b1, held_codes[s]));
                    held_codes[s] = C_EMPTY_CODE;
                end
            end
        end

        // new keys into the first free slot, dropped when full
        for (j = 0; j < n_keys; j++) begin
            if (codes[j] != C_EMPTY_CODE) begin
                found = 1'b0;
                for (s = 0; s < HELD_SLOTS; s++)
                    if (held_codes[s] == codes[j])
                        found = 1'b1;
                placed = 1'b0;
                for (s = 0; s < HELD_SLOTS; s++) begin
                    if (!found && !placed && held_codes[s] == C_EMPTY_CODE) begin
                        held_codes[s] = codes[j];
                        evs.push_back(make_event(1'b0, codes[j]));
                        placed = 1'b1;
                    end
                end
            end
        end

        if (evs.size() > 0)
            evs[evs.size()-1].last_event = 1'b1;
        foreach (evs[k])
            expected_events.push_back(evs[k]);
    endfunction

    task automatic queue_report(
        input logic [C_MOD_BITS-1:0] mods,
        input logic [3:0]            n_keys,
        input logic [C_KEY_W-1:0]    k0, k1, k2, k3, k4, k5, k6, k7
    );
        t_report r;
        r.modifier_bits = mods;
        r.key_count     = n_keys;
        r.key_0 = k0;
        r.key_1 = k1;
        r.key_2 = k2;
        r.key_3 = k3;
        r.key_4 = k4;
        r.key_5 = k5;
        r.key_6 = k6;
        r.key_7 = k7;
        pending_reports.push_back(r);
    endtask

    // mostly pool codes so keys stay held across reports
    function automatic logic [C_KEY_W-1:0] random_key();
        logic [C_KEY_W-1:0] k;
        int r;
        k = code_pool[$urandom_range(0, POOL_SIZE-1)];
        r = $urandom_range(0, 99);
        if (r < 10)
            k = k ^ KEYPAD_BIT;
        else if (r < 12)
            k = $urandom_range(0, 1) ? C_EMPTY_CODE : KEYPAD_BIT;
        else if (r < 22)
            k = 16'($urandom);
        return k;
    endfunction

    // random reports: rollover edits of the last report, plus fresh ones
    task automatic run_random(input int n_items);
        int i, r, j;
        foreach (code_pool[p])
            code_pool[p] = 16'($urandom);
        for (i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45 && stim_count != 0) begin
                case ($urandom_range(0, 2))
                    0: if (stim_count < C_MAX_KEYS) stim_count = stim_count + 4'd1;
                    1: if (stim_count > 1) stim_count = stim_count - 4'd1;
                    default: ;
                endcase
                stim_keys[$urandom_range(0, C_MAX_KEYS-1)] = random_key();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    stim_count = 4'd0;
                else if (r < 12)
                    stim_count = 4'($urandom_range(9, 15));
                else
                    stim_count = 4'($urandom_range(1, 8));
                for (j = 0; j < C_MAX_KEYS; j++)
                    stim_keys[j] = random_key();
            end
            r = $urandom_range(0, 99);
            if (r >= 60)
                stim_mods = 8'($urandom);
            else if (r >= 50)
                stim_mods = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            queue_report(stim_mods, stim_count, stim_keys[0], stim_keys[1], stim_keys[2],
                         stim_keys[3], stim_keys[4], stim_keys[5], stim_keys[6],
                         stim_keys[7]);
        end
    endtask

    // wait until every report is taken and every event has come out
    task automatic wait_idle();
        while (pending_reports.size() != 0 || in_valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one mask write, called at a rising edge
    task automatic write_mask(input logic [C_KEY_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        keypad_mask = value;
        cfg_valid <= 1'b0;
    endtask

    // report driver
    always @(posedge clk) begin : report_driver
        logic next_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            if (in_valid && in_ready) begin
                predict_events(in_report);
                next_valid = 1'b0;
            end
            if (drain_pause && expected_events.size() == 0)
                drain_pause = 1'b0;
            if (!next_valid && pending_reports.size() != 0 && !drain_pause) begin
                // now and then hold off until all events are out
                if ($urandom_range(0, 99) < 3) begin
                    drain_pause = 1'b1;
                end else if ($urandom_range(0, 99) >= send_idle_pct) begin
                    in_report <= pending_reports.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // event monitor
    always @(posedge clk) begin : event_monitor
        t_event want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_events.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected event: expected none, actual %b %h %b",
                             $time, out_event.is_release, out_event.event_code,
                             out_event.last_event);
                end else begin
                    want = expected_events.pop_front();
                    if (out_event.is_release !== want.is_release) begin
                        error_count++;
                        $display("%0t: is_release mismatch: expected %b, actual %b",
                                 $time, want.is_release, out_event.is_release);
                    end
                    if (out_event.event_code !== want.event_code) begin
                        error_count++;
                        $display("%0t: event_code mismatch: expected %h, actual %h",
                                 $time, want.event_code, out_event.event_code);
                    end
                    if (out_event.last_event !== want.last_event) begin
                        error_count++;
                        $display("%0t: last_event mismatch: expected %b, actual %b",
                                 $time, want.last_event, out_event.last_event);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // run time limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("key_report_to_press_release_events_tb failed");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 16;
        recv_idle_pct = 54;
        write_mask(C_MASK_RESET);

        // directed reports under the default mask
        queue_report(8'hFF, 4'd0, 'h0004, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0);
        queue_report(8'h00, 4'd1, 'h0004, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0);
        queue_report(8'hFF, 4'd1, 'h0004, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0);
        queue_report(8'hFF, 4'd1, 'h0004, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0);
        queue_report(8'h00, 4'd8, 'h0001, 'h0002, 'h0003, 'h0004,
                     'h0005, 'h0006, 'h0007, 'h0008);
        queue_report(8'h55, 4'd8, 'h0001, 'h0002, 'h0003, 'h0004,
                     'h0005, 'h0006, 'h0007, 'h4009);
        // count above the report size, all keys the same after masking
        queue_report(8'hAA, 4'd15, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
                     'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF);
        // zero codes release the table
        queue_report(8'hAA, 4'd9, 'h0000, 'h0011, 'h0012, 'h0013,
                     'h0014, 'h0015, 'h0016, 'h0017);
        queue_report(8'h80, 4'd3, 'h4000, 'h0021, 'h0021, 'h0, 'h0, 'h0, 'h0, 'h0);
        // duplicates through the keypad flag
        queue_report(8'h01, 4'd4, 'h0021, 'h4021, 'h0022, 'h0023, 'h0, 'h0, 'h0, 'h0);
        queue_report(8'h01, 4'd2, 'h0022, 'h0024, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0);
        queue_report(8'h01, 4'd0, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0);
        // walking ones and zeros in the key codes
        queue_report(8'h00, 4'd8, 'h0101, 'h0202, 'h0404, 'h0808,
                     'h1010, 'h2020, 'h4040, 'h8080);
        queue_report(8'hFF, 4'd8, 'hFEFE, 'hFDFD, 'hFBFB, 'hF7F7,
                     'hEFEF, 'hDFDF, 'hBFBF, 'h7F7F);
        queue_report(8'h00, 4'd1, 'h7FFF, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0);
        queue_report(8'h00, 4'd8, 'h0031, 'h0032, 'h0033, 'h0034,
                     'h0035, 'h0036, 'h0037, 'h0038);
        queue_report(8'h00, 4'd8, 'h0041, 'h0042, 'h0043, 'h0044,
                     'h0045, 'h0046, 'h0047, 'h0048);
        // most events a report can cause
        queue_report(8'hFF, 4'd8, 'h0051, 'h0052, 'h0053, 'h0054,
                     'h0055, 'h0056, 'h0057, 'h0058);
        queue_report(8'h00, 4'd1, 'h0000, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0, 'h0);
        queue_report(8'h0F, 4'd8, 'h4000, 'h4000, 'h4000, 'h4000,
                     'h4000, 'h4000, 'h4000, 'h4000);

        run_random(60);

        wait_idle();
        write_mask(16'h0000);
        run_random(50);

        wait_idle();
        send_idle_pct = 54;
        recv_idle_pct = 16;
        write_mask(16'hFFFF);
        run_random(12);

        wait_idle();
        write_mask(16'($urandom & $urandom));
        run_random(50);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mask(C_MASK_RESET);
        run_random(50);

        wait_idle();
        if (error_count == 0)
            $display("key_report_to_press_release_events_tb passed");
        else
            $display("key_report_to_press_release_events_tb failed");
        $finish;
    end

endmodule
